@@ hdl/kab_pkg.sv @@
// ----------------------------------------------------------------------------
// kab_pkg: shared types, constants and arithmetic helpers
// Widths, reset values and sequencer codes of the angle and bias filter.
// ----------------------------------------------------------------------------
package kab_pkg;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned OPND_W  = 34;
	localparam int unsigned PROD_W  = 2 * OPND_W;
	localparam int unsigned WIDE_W  = PROD_W + 2;
	localparam int unsigned ANGLE_W = 25;
	localparam int unsigned RATE_W  = 28;
	localparam int unsigned DT_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [DATA_W-1:0] RESET_ANGLE_NOISE = 32'd10737418;
	localparam logic [DATA_W-1:0] RESET_BIAS_NOISE  = 32'd322123;
	localparam logic [DATA_W-1:0] RESET_MEAS_NOISE  = 32'd10737418;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_NOISE = 2'd0,
		REG_BIAS_NOISE  = 2'd1,
		REG_MEAS_NOISE  = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT_MUL,
		ST_WAIT_DIV,
		ST_FINISH
	} state_t;

	typedef enum logic [3:0] {
		OP_ANG, OP_P00A, OP_P00B, OP_P01, OP_P11, OP_K0, OP_K1,
		OP_UPD_ANG, OP_UPD_BIAS, OP_UPD_AA, OP_UPD_AB, OP_UPD_BA, OP_UPD_BB
	} op_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(32'sh7fffffff);
		lo = -(WIDE_W'(32'sh7fffffff)) - WIDE_W'(1);
		if (v > hi) return 32'sh7fffffff;
		if (v < lo) return 32'sh80000000;
		return v[DATA_W-1:0];
	endfunction

	// Round to nearest with ties toward plus infinity, then arithmetic shift.
	function automatic logic signed [PROD_W-1:0] rnd_shift(input logic signed [PROD_W-1:0] v,
			input int unsigned s);
		logic signed [PROD_W-1:0] half;
		half = PROD_W'(1) <<< (s - 1);
		return (v + half) >>> s;
	endfunction

endpackage

@@ hdl/kab_if.sv @@
// ----------------------------------------------------------------------------
// kab_if: sample and result channels
// Valid/ready channels carrying one sample in and one estimate out.
// ----------------------------------------------------------------------------
interface kab_sample_if import kab_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [ANGLE_W-1:0]  accel_angle;
	logic signed [RATE_W-1:0]   gyro_rate;
	logic        [DT_W-1:0]     time_step;
	modport source (output valid, accel_angle, gyro_rate, time_step, input ready);
	modport sink (input valid, accel_angle, gyro_rate, time_step, output ready);
endinterface

interface kab_result_if import kab_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DATA_W-1:0]  angle_estimate;
	logic signed [DATA_W-1:0]  bias_estimate;
	modport source (output valid, angle_estimate, bias_estimate, input ready);
	modport sink (input valid, angle_estimate, bias_estimate, output ready);
endinterface

@@ hdl/kalman_angle_bias_filter.sv @@
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter: two-state angle and gyro bias Kalman filter
// Fuses an accelerometer angle with a gyro rate and returns angle and bias.
// ----------------------------------------------------------------------------
// One sample is worked at a time, from acceptance to result. Eleven products
// go through a bit-serial multiplier, and two gains go through a bit-serial
// divider. On finish the estimates are loaded into the output register.
// A finished result waits in the output register, so the next sample is
// accepted while it is still pending; a further result waits in the finish
// step until the pending one is taken. The user must write the noise
// registers through the cfg port only while no sample is in flight; the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter import kab_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [DATA_W-1:0]     cfg_data,
	kab_sample_if.sink            sample,
	kab_result_if.source          result
);
	logic [DATA_W-1:0] angle_noise_q, bias_noise_q, meas_noise_q;

	state_t state_q, state_d;
	op_t    op_q;

	logic signed [ANGLE_W-1:0] meas_q;
	logic signed [RATE_W-1:0]  rate_q;
	logic        [DT_W-1:0]    dt_q;

	logic signed [DATA_W-1:0] angle_q, bias_q, aa_q, ab_q, ba_q, bb_q;
	logic signed [DATA_W-1:0] ang_q, p00_q, p01_q, p10_q, p11_q, y_q, k0_q, k1_q;
	logic signed [35:0]       tmp_q;
	logic                     res_valid_q;
	logic signed [DATA_W-1:0] res_angle_q, res_bias_q;

	logic                     mul_start, mul_busy, mul_done;
	logic signed [OPND_W-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0] prod, r16, r30;
	logic                     div_start, div_busy, div_done;
	logic signed [DATA_W-1:0] div_num, quot;
	logic signed [OPND_W:0]   s_sum;
	logic                     s_pos;
	logic                     is_div;

	kab_mul u_mul (.clk, .arst_n, .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .done(mul_done), .prod);
	kab_div u_div (.clk, .arst_n, .start(div_start), .num(div_num),
		.den(s_sum[OPND_W-1:0]), .busy(div_busy), .done(div_done), .quot);

	assign r16   = rnd_shift(prod, 16);
	assign r30   = rnd_shift(prod, 30);
	assign s_sum = (OPND_W+1)'(p00_q) + (OPND_W+1)'({1'b0, meas_noise_q});
	assign s_pos = !s_sum[OPND_W] && (s_sum != '0);
	assign is_div = (op_q == OP_K0) || (op_q == OP_K1);
	assign div_num = (op_q == OP_K1) ? p10_q : p00_q;

	always_comb begin
		mul_a = '0;
		mul_b = OPND_W'({1'b0, dt_q});
		case (op_q)
			OP_ANG:      mul_a = OPND_W'(rate_q) - OPND_W'(bias_q);
			OP_P00A:     mul_a = OPND_W'(ba_q) + OPND_W'(ab_q);
			OP_P00B:     mul_a = OPND_W'({1'b0, angle_noise_q});
			OP_P01:      mul_a = OPND_W'(bb_q);
			OP_P11:      mul_a = OPND_W'({1'b0, bias_noise_q});
			OP_UPD_ANG:  begin mul_a = OPND_W'(k0_q); mul_b = OPND_W'(y_q);   end
			OP_UPD_BIAS: begin mul_a = OPND_W'(k1_q); mul_b = OPND_W'(y_q);   end
			OP_UPD_AA:   begin mul_a = OPND_W'(k0_q); mul_b = OPND_W'(p00_q); end
			OP_UPD_AB:   begin mul_a = OPND_W'(k0_q); mul_b = OPND_W'(p01_q); end
			OP_UPD_BA:   begin mul_a = OPND_W'(k1_q); mul_b = OPND_W'(p00_q); end
			OP_UPD_BB:   begin mul_a = OPND_W'(k1_q); mul_b = OPND_W'(p01_q); end
			default:     mul_a = '0;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (sample.valid) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (is_div) begin
					div_start = 1'b1;
					state_d   = ST_WAIT_DIV;
				end else begin
					mul_start = 1'b1;
					state_d   = ST_WAIT_MUL;
				end
			end
			ST_WAIT_MUL: begin
				if (mul_done) state_d = (op_q == OP_UPD_BB) ? ST_FINISH : ST_ISSUE;
			end
			ST_WAIT_DIV: begin
				if (div_done) state_d = ST_ISSUE;
			end
			ST_FINISH: begin
				if (!res_valid_q || result.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign sample.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			op_q          <= OP_ANG;
			res_valid_q   <= 1'b0;
			angle_noise_q <= RESET_ANGLE_NOISE;
			bias_noise_q  <= RESET_BIAS_NOISE;
			meas_noise_q  <= RESET_MEAS_NOISE;
			angle_q <= '0; bias_q <= '0;
			aa_q <= '0; ab_q <= '0; ba_q <= '0; bb_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_ANGLE_NOISE: angle_noise_q <= cfg_data;
					REG_BIAS_NOISE:  bias_noise_q  <= cfg_data;
					REG_MEAS_NOISE:  meas_noise_q  <= cfg_data;
					default: ;
				endcase
			end
			if (result.valid && result.ready) res_valid_q <= 1'b0;
			if (state_q == ST_FINISH && state_d == ST_IDLE) res_valid_q <= 1'b1;
			if (sample.valid && sample.ready) op_q <= OP_ANG;
			if (div_done) op_q <= op_t'(op_q + 4'd1);
			if (mul_done) begin
				if (op_q != OP_UPD_BB) op_q <= op_t'(op_q + 4'd1);
				case (op_q)
					OP_UPD_ANG:  angle_q <= sat32(WIDE_W'(ang_q) + WIDE_W'(r30));
					OP_UPD_BIAS: bias_q  <= sat32(WIDE_W'(bias_q) + WIDE_W'(r30));
					OP_UPD_AA:   aa_q    <= sat32(WIDE_W'(p00_q) - WIDE_W'(r30));
					OP_UPD_AB:   ab_q    <= sat32(WIDE_W'(p01_q) - WIDE_W'(r30));
					OP_UPD_BA:   ba_q    <= sat32(WIDE_W'(p10_q) - WIDE_W'(r30));
					OP_UPD_BB:   bb_q    <= sat32(WIDE_W'(p11_q) - WIDE_W'(r30));
					default: ;
				endcase
			end
		end
	end

	// Working registers of one sample; no reset needed.
	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			meas_q <= sample.accel_angle;
			rate_q <= sample.gyro_rate;
			dt_q   <= sample.time_step;
		end
		if (mul_done) begin
			case (op_q)
				OP_ANG:  ang_q <= sat32(WIDE_W'(angle_q) + WIDE_W'(r16));
				OP_P00A: tmp_q <= 36'(aa_q) - 36'(r16);
				OP_P00B: p00_q <= sat32(WIDE_W'(tmp_q) + WIDE_W'(r16));
				OP_P01: begin
					p01_q <= sat32(WIDE_W'(ab_q) - WIDE_W'(r16));
					p10_q <= sat32(WIDE_W'(ba_q) - WIDE_W'(r16));
				end
				OP_P11: begin
					p11_q <= sat32(WIDE_W'(bb_q) + WIDE_W'(r16));
					y_q   <= sat32(WIDE_W'(meas_q) - WIDE_W'(ang_q));
				end
				default: ;
			endcase
		end
		if (div_done) begin
			if (op_q == OP_K0) k0_q <= s_pos ? quot : '0;
			else k1_q <= s_pos ? quot : '0;
		end
		if (state_q == ST_FINISH && state_d == ST_IDLE) begin
			res_angle_q <= angle_q;
			res_bias_q  <= bias_q;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.angle_estimate = res_angle_q;
	assign result.bias_estimate  = res_bias_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy && div_busy))
		else $error("multiplier and divider busy together");
	a_div_op: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT_DIV) |-> (op_q == OP_K0 || op_q == OP_K1))
		else $error("divider wait outside a gain step");
	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finish step");
endmodule

@@ hdl/kab_mul.sv @@
// ----------------------------------------------------------------------------
// kab_mul: bit-serial signed multiplier
// Consumes the multiplier one bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module kab_mul import kab_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [OPND_W-1:0]  a,
	input  logic signed [OPND_W-1:0]  b,
	output logic                      busy,
	output logic                      done,
	output logic signed [PROD_W-1:0]  prod
);
	localparam int unsigned CNT_W = $clog2(OPND_W + 1);

	logic signed [OPND_W-1:0] a_q;
	logic        [OPND_W-1:0] b_q;
	logic signed [PROD_W-1:0] acc_q;
	logic        [CNT_W-1:0]  cnt_q;
	logic                     first_q;
	logic                     busy_q;
	logic                     done_q;
	logic signed [PROD_W-1:0] addend;

	// The sign bit of the multiplier carries negative weight.
	always_comb begin
		addend = '0;
		if (b_q[OPND_W-1]) begin
			addend = first_q ? -PROD_W'(a_q) : PROD_W'(a_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			first_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= CNT_W'(OPND_W);
				first_q <= 1'b1;
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< 1) + addend;
			b_q   <= b_q << 1;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign prod = acc_q;
endmodule

@@ hdl/kab_div.sv @@
// ----------------------------------------------------------------------------
// kab_div: bit-serial gain divider
// Restoring division of num * 2^30 by a positive divisor, one quotient bit
// per cycle, truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module kab_div import kab_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic signed [DATA_W-1:0]  num,
	input  logic        [OPND_W-1:0]  den,
	output logic                      busy,
	output logic                      done,
	output logic signed [DATA_W-1:0]  quot
);
	localparam int unsigned DVD_W = DATA_W + 30;
	localparam int unsigned CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic [OPND_W-1:0] rem_q;
	logic [OPND_W-1:0] den_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [OPND_W:0]   trial;
	logic              fits;
	logic [DATA_W-1:0] mag;

	assign mag   = num[DATA_W-1] ? DATA_W'(-(DATA_W+1)'(num)) : num;
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag, 30'b0};
			quo_q <= '0;
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[DATA_W-1];
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? OPND_W'(trial - {1'b0, den_q}) : trial[OPND_W-1:0];
		end
	end

	always_comb begin
		if (neg_q) begin
			quot = (quo_q > DVD_W'(33'h080000000)) ? 32'sh80000000
			                                       : DATA_W'(-quo_q[DATA_W-1:0]);
		end else begin
			quot = (quo_q > DVD_W'(32'h7fffffff)) ? 32'sh7fffffff : quo_q[DATA_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
endmodule

@@ bench/kalman_angle_bias_filter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_test: self-checking bench for the angle/bias filter
// Drives samples in random bursts under several noise settings, tracks the
// filter state in a bit-exact software copy, and checks every estimate.
// ----------------------------------------------------------------------------

import kab_pkg::*;

typedef struct {
	logic signed [DATA_W-1:0] angle;
	logic signed [DATA_W-1:0] bias;
} estimate_t;

class kab_tracker;
	logic [DATA_W-1:0] angle_noise, bias_noise, meas_noise;
	longint angle_st, bias_st, c_aa, c_ab, c_ba, c_bb;
	estimate_t pending_q[$];
	int errors;

	function new();
		angle_noise = RESET_ANGLE_NOISE;
		bias_noise  = RESET_BIAS_NOISE;
		meas_noise  = RESET_MEAS_NOISE;
		angle_st = 0; bias_st = 0; c_aa = 0; c_ab = 0; c_ba = 0; c_bb = 0;
		errors = 0;
	endfunction

	function longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Round to nearest, ties toward plus infinity.
	function longint round_shift(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function longint gain(longint num, longint s);
		return clamp32((num <<< 30) / s);
	endfunction

	function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
		case (idx)
			REG_ANGLE_NOISE: angle_noise = val;
			REG_BIAS_NOISE:  bias_noise = val;
			REG_MEAS_NOISE:  meas_noise = val;
			default: ;
		endcase
	endfunction

	function void note_sample(logic signed [ANGLE_W-1:0] acc, logic signed [RATE_W-1:0] gyr,
			logic [DT_W-1:0] dt_in);
		longint meas, rate, dt, ang, p00, p01, p10, p11, y, s, k0, k1;
		estimate_t e;
		meas = acc;
		rate = gyr;
		dt = longint'(dt_in);
		ang = clamp32(angle_st + round_shift((rate - bias_st) * dt, 16));
		p00 = clamp32(c_aa - round_shift((c_ba + c_ab) * dt, 16)
			+ round_shift(longint'(angle_noise) * dt, 16));
		p01 = clamp32(c_ab - round_shift(c_bb * dt, 16));
		p10 = clamp32(c_ba - round_shift(c_bb * dt, 16));
		p11 = clamp32(c_bb + round_shift(longint'(bias_noise) * dt, 16));
		y = clamp32(meas - ang);
		s = p00 + longint'(meas_noise);
		if (s > 0) begin
			k0 = gain(p00, s);
			k1 = gain(p10, s);
		end else begin
			k0 = 0;
			k1 = 0;
		end
		angle_st = clamp32(ang + round_shift(k0 * y, 30));
		bias_st = clamp32(bias_st + round_shift(k1 * y, 30));
		c_aa = clamp32(p00 - round_shift(k0 * p00, 30));
		c_ab = clamp32(p01 - round_shift(k0 * p01, 30));
		c_ba = clamp32(p10 - round_shift(k1 * p00, 30));
		c_bb = clamp32(p11 - round_shift(k1 * p01, 30));
		e.angle = angle_st[DATA_W-1:0];
		e.bias = bias_st[DATA_W-1:0];
		pending_q.push_back(e);
	endfunction

	function void check_result(logic signed [DATA_W-1:0] ang, logic signed [DATA_W-1:0] bias);
		estimate_t e;
		if (pending_q.size() == 0) begin
			$display("%0t: unexpected estimate angle=%0d bias=%0d", $time, ang, bias);
			errors++;
			return;
		end
		e = pending_q.pop_front();
		if (ang !== e.angle) begin
			$display("%0t: angle_estimate expected %0d actual %0d", $time, e.angle, ang);
			errors++;
		end
		if (bias !== e.bias) begin
			$display("%0t: bias_estimate expected %0d actual %0d", $time, e.bias, bias);
			errors++;
		end
	endfunction
endclass

module kalman_angle_bias_filter_test;
	localparam int ACC_MAX = 11796480;
	localparam int GYRO_MAX = 131072000;
	localparam longint CYCLE_LIMIT = 8000000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;
	longint cycles;
	logic [15:0] stall_pat;
	int burst_left;

	kab_sample_if sample ();
	kab_result_if result ();
	kab_tracker tracker;

	kalman_angle_bias_filter u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .sample(sample.sink), .result(result.source)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: stalls follow a 16-bit pattern that is reloaded now and then.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("kalman_angle_bias_filter_test: FAIL");
			$finish;
		end
		if (arst_n && result.valid && result.ready)
			tracker.check_result(result.angle_estimate, result.bias_estimate);
		if (cycles % 64 == 0)
			stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom);
		else
			stall_pat <= {stall_pat[0], stall_pat[15:1]};
		result.ready <= stall_pat[0];
	end

	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		tracker.set_reg(idx, val);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_sample(int acc, int gyr, int dt, bit last);
		sample.valid <= 1'b1;
		sample.accel_angle <= ANGLE_W'(acc);
		sample.gyro_rate <= RATE_W'(gyr);
		sample.time_step <= DT_W'(dt);
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		tracker.note_sample(ANGLE_W'(acc), RATE_W'(gyr), DT_W'(dt));
		burst_left--;
		if (last) begin
			sample.valid <= 1'b0;
		end else if (burst_left <= 0) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 10);
		end
	endtask

	task automatic drain();
		while (tracker.pending_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		int acc, gyr, dt, kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				// Typical IMU traffic: modest rates and short time steps.
				acc = $urandom_range(0, 2 * 90 * 65536) - 90 * 65536;
				gyr = $urandom_range(0, 2 * 500 * 65536) - 500 * 65536;
				dt = $urandom_range(0, 1500);
			end else if (kind < 9) begin
				acc = $urandom_range(0, 2 * ACC_MAX) - ACC_MAX;
				gyr = $urandom_range(0, 2 * GYRO_MAX) - GYRO_MAX;
				dt = $urandom_range(0, 65535);
			end else begin
				acc = $urandom_range(0, 1) ? ACC_MAX : -ACC_MAX;
				gyr = $urandom_range(0, 1) ? GYRO_MAX : -GYRO_MAX;
				dt = $urandom_range(0, 1) ? 65535 : 0;
			end
			send_sample(acc, gyr, dt, i == n - 1);
		end
	endtask

	initial begin
		tracker = new();
		cycles = 0;
		stall_pat = 16'hffff;
		burst_left = 4;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ANGLE_NOISE;
		cfg_data = '0;
		sample.valid = 1'b0;
		sample.accel_angle = '0;
		sample.gyro_rate = '0;
		sample.time_step = '0;
		result.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, zero and full time steps.
		send_sample(0, 0, 0, 0);
		send_sample(ACC_MAX, GYRO_MAX, 65535, 0);
		send_sample(-ACC_MAX, -GYRO_MAX, 65535, 0);
		send_sample(ACC_MAX, -GYRO_MAX, 1, 0);
		send_sample(-ACC_MAX, GYRO_MAX, 0, 0);
		send_sample(0, 0, 65535, 0);
		send_sample(-1, -1, 1, 0);
		send_sample(1, 1, 32768, 0);
		send_sample(ACC_MAX, 0, 100, 1);
		drain();

		random_phase(400);
		drain();

		// Largest noise terms: covariance saturates quickly.
		write_reg(REG_ANGLE_NOISE, 32'hffffffff);
		write_reg(REG_BIAS_NOISE, 32'hffffffff);
		write_reg(REG_MEAS_NOISE, 32'hffffffff);
		random_phase(400);
		drain();

		// Smallest noise terms; large time steps can drive the angle variance negative.
		write_reg(REG_ANGLE_NOISE, 32'h0);
		write_reg(REG_BIAS_NOISE, 32'h0);
		write_reg(REG_MEAS_NOISE, 32'h1);
		random_phase(400);
		drain();

		write_reg(REG_ANGLE_NOISE, $urandom);
		write_reg(REG_BIAS_NOISE, $urandom);
		write_reg(REG_MEAS_NOISE, $urandom_range(1, 32'hffffffff));
		random_phase(400);
		drain();

		write_reg(REG_ANGLE_NOISE, RESET_ANGLE_NOISE);
		write_reg(REG_BIAS_NOISE, RESET_BIAS_NOISE);
		write_reg(REG_MEAS_NOISE, RESET_MEAS_NOISE);
		random_phase(400);
		drain();

		repeat (600) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_q.size() == 0)
			$display("kalman_angle_bias_filter_test: PASS");
		else
			$display("kalman_angle_bias_filter_test: FAIL");
		$finish;
	end
endmodule
